// File: rtl/dmwc_pkg.sv
// Package: payload types and constants for the direct-mapped word cache.
package dmwc_pkg;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;
  localparam logic [2:0] MAX_CYCLES = 3'd5;
  localparam logic [15:0] BYTE_MASK = 16'h00FF;

  typedef struct packed {
    logic        opcode;
    logic [15:0] address;
    logic        byte_access;
    logic [15:0] write_data;
  } in_item_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic        hit;
    logic [2:0]  access_cycles;
  } out_item_t;

endpackage

// File: rtl/dmwc_front.sv
// Front: two-entry queue feeding the back end.
module dmwc_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  dmwc_pkg::in_item_t in_item,
  output logic               q_valid,
  input  logic               q_take,
  output dmwc_pkg::in_item_t q_item
);
  dmwc_pkg::in_item_t buf_r [2];
  logic [1:0] cnt_r;
  logic       rd_r;
  logic       wr_r;
  logic       push;

  assign in_stall = (cnt_r == 2'd2);
  assign push = in_valid && !in_stall;
  assign q_valid = (cnt_r != 2'd0);
  assign q_item = buf_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      rd_r <= 1'b0;
      wr_r <= 1'b0;
    end else begin
      if (push) begin
        buf_r[wr_r] <= in_item;
        wr_r <= ~wr_r;
      end
      if (q_take) rd_r <= ~rd_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_take};
    end
  end
endmodule

// File: rtl/dmwc_back.sv
// Back: line store, backing memory and the access sequencer.
module dmwc_back #(
  parameter int LINES = 32,
  parameter int MEM_WORDS = 32768
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                write_through,
  input  logic                q_valid,
  output logic                q_take,
  input  dmwc_pkg::in_item_t  q_item,
  output logic                out_valid,
  input  logic                out_stall,
  output dmwc_pkg::out_item_t out_item
);
  localparam int IW = $clog2(LINES);
  localparam int MW = $clog2(MEM_WORDS);
  localparam int TW = 15 - IW;

  typedef enum logic [1:0] {S_IDLE, S_LOOK, S_FILL, S_DONE} state_t;

  logic [15:0] mem [MEM_WORDS];
  logic [15:0] line_word [LINES];
  logic [TW-1:0] line_tag [LINES];
  logic [LINES-1:0] valid_r, dirty_r;

  state_t state_r;
  dmwc_pkg::in_item_t cur_r;
  logic [15:0] lw_r, mrd_r;
  logic [TW-1:0] lt_r;
  logic hit_r;
  dmwc_pkg::out_item_t out_r;
  logic ovalid_r;

  logic [14:0] waddr;
  logic [IW-1:0] idx;
  logic [TW-1:0] tag;
  logic [14:0] victim;
  logic [15:0] w, nw, rd;
  logic [2:0] cyc;
  logic vhit;

  assign waddr = cur_r.address[15:1];
  assign idx = waddr[IW-1:0];
  assign tag = waddr[14:IW];
  assign victim = {lt_r, idx};
  assign vhit = valid_r[idx] && (lt_r == tag);

  always_comb begin
    w = hit_r ? lw_r : mrd_r;
    if (cur_r.address[0]) begin
      rd = (w >> 8) & dmwc_pkg::BYTE_MASK;
      nw = {cur_r.write_data[7:0], w[7:0]};
    end else if (cur_r.byte_access) begin
      rd = w & dmwc_pkg::BYTE_MASK;
      nw = {w[15:8], cur_r.write_data[7:0]};
    end else begin
      rd = w;
      nw = cur_r.write_data;
    end
    cyc = 3'd1;
    if (!hit_r) cyc = (valid_r[idx] && dirty_r[idx]) ? 3'd5 : 3'd3;
    if (cur_r.opcode == dmwc_pkg::OP_WRITE && write_through && cyc < dmwc_pkg::MAX_CYCLES)
      cyc = cyc + 3'd2;
  end

  assign q_take = (state_r == S_IDLE) && q_valid;
  assign out_valid = ovalid_r;
  assign out_item = out_r;

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE) begin
      lw_r <= line_word[q_item.address[IW:1]];
      lt_r <= line_tag[q_item.address[IW:1]];
    end
    if (state_r == S_LOOK) begin
      mrd_r <= mem[waddr[MW-1:0]];
      if (!vhit && valid_r[idx] && dirty_r[idx]) mem[victim[MW-1:0]] <= lw_r;
    end
    if (state_r == S_FILL && !(ovalid_r && out_stall)) begin
      if (cur_r.opcode == dmwc_pkg::OP_WRITE) begin
        line_word[idx] <= nw;
        if (write_through) mem[waddr[MW-1:0]] <= nw;
      end else begin
        line_word[idx] <= w;
      end
      line_tag[idx] <= tag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= '0;
      dirty_r <= '0;
      ovalid_r <= 1'b0;
    end else begin
      if (ovalid_r && !out_stall && state_r != S_FILL) ovalid_r <= 1'b0;
      case (state_r)
        S_IDLE: if (q_valid) begin
          cur_r <= q_item;
          state_r <= S_LOOK;
        end
        S_LOOK: begin
          hit_r <= vhit;
          state_r <= S_FILL;
        end
        S_FILL: if (!(ovalid_r && out_stall)) begin
          out_r.read_data <= (cur_r.opcode == dmwc_pkg::OP_WRITE) ? 16'd0 : rd;
          out_r.hit <= hit_r;
          out_r.access_cycles <= cyc;
          ovalid_r <= 1'b1;
          valid_r[idx] <= 1'b1;
          dirty_r[idx] <= (cur_r.opcode == dmwc_pkg::OP_WRITE) ? !write_through
                                                               : (hit_r && dirty_r[idx]);
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

// File: rtl/direct_mapped_word_cache_top.sv
// Top level: direct-mapped word cache with write-through/write-back mode.
// Path: an accepted item passes the queue, then the lookup and memory/merge states, and the result is registered.
// Items are handled one at a time by the three-state back-end sequencer (take, lookup,
// memory/merge); the next item is taken only once the last is done, and out_stall holds it.
// Reset: line valid and dirty bits cleared at once, write_through set to 1;
// backing memory is not cleared.
module direct_mapped_word_cache_top #(
  parameter int LINES = 32,
  parameter int MEM_WORDS = 32768
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  dmwc_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output dmwc_pkg::out_item_t out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_data
);
  logic wt_r;
  logic q_valid, q_take;
  dmwc_pkg::in_item_t q_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) wt_r <= 1'b1;
    else if (cfg_valid) wt_r <= cfg_data;
  end

  dmwc_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_item,
    .q_valid, .q_take, .q_item
  );

  dmwc_back #(.LINES(LINES), .MEM_WORDS(MEM_WORDS)) u_back (
    .clk, .rst_n, .write_through(wt_r), .q_valid, .q_take, .q_item,
    .out_valid, .out_stall, .out_item
  );
endmodule
